>>> design/cbt_pkg.sv
`timescale 1ns / 1ps

package cbt_pkg;

   localparam int OFFSET_BITS  = 16;
   localparam int REPLAY_DEPTH = 16;
   localparam int CNT_W        = $clog2(REPLAY_DEPTH + 1);
   localparam int IDX_W        = $clog2(REPLAY_DEPTH);
   localparam int LOOK         = 10;
   localparam int MATCH_MAX    = 9;
   localparam int BYTE_W       = 8;
   localparam int KIND_W       = 5;
   localparam int FIELD_W      = 16;
   localparam int TAKE_W       = 4;

   localparam logic [KIND_W-1:0] K_DOT       = 5'd9;
   localparam logic [KIND_W-1:0] K_MINUS     = 5'd11;
   localparam logic [KIND_W-1:0] K_SLASH     = 5'd13;
   localparam logic [KIND_W-1:0] K_IDENT     = 5'd20;
   localparam logic [KIND_W-1:0] K_FUNCTION  = 5'd21;
   localparam logic [KIND_W-1:0] K_NUMBER    = 5'd22;
   localparam logic [KIND_W-1:0] K_PERCENT   = 5'd23;
   localparam logic [KIND_W-1:0] K_DIMENSION = 5'd24;
   localparam logic [KIND_W-1:0] K_HASH      = 5'd25;
   localparam logic [KIND_W-1:0] K_ATKW      = 5'd26;
   localparam logic [KIND_W-1:0] K_STRING    = 5'd27;
   localparam logic [KIND_W-1:0] K_IMPORTANT = 5'd28;
   localparam logic [KIND_W-1:0] K_CDO       = 5'd29;
   localparam logic [KIND_W-1:0] K_ERROR     = 5'd30;
   localparam logic [KIND_W-1:0] K_END       = 5'd31;

   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

   localparam logic [BYTE_W-1:0] IMPORTANT_WORD [MATCH_MAX] =
      '{"i", "m", "p", "o", "r", "t", "a", "n", "t"};
   localparam logic [BYTE_W-1:0] CDO_WORD [MATCH_MAX] =
      '{"!", "-", "-", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
   localparam logic [TAKE_W-1:0] IMPORTANT_LEN = 4'd9;
   localparam logic [TAKE_W-1:0] CDO_LEN       = 4'd3;

   typedef enum logic [4:0] {
      M_IDLE    = 5'd0,
      M_IDENT   = 5'd1,
      M_NUMINT  = 5'd2,
      M_NUMFRAC = 5'd3,
      M_UNIT    = 5'd4,
      M_STRING  = 5'd5,
      M_STRESC  = 5'd6,
      M_COMMENT = 5'd7,
      M_HASH    = 5'd8,
      M_AT      = 5'd9
   } cbt_mode_type;

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_RUN,
      ST_TAKE,
      ST_EMIT,
      ST_END,
      ST_FLUSH
   } cbt_state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] length;
      logic [FIELD_W-1:0] line;
      logic [FIELD_W-1:0] column;
      logic               hash_id;
   } cbt_token_type;

   typedef struct packed {
      logic load_byte;
      logic apply;
      logic take;
      logic emit;
      logic end_tok;
      logic flush;
   } cbt_cmd_type;

   typedef struct packed {
      logic stop;
      logic ending;
      logic takes_left;
      logic emit_pend;
      logic held_valid;
      logic out_free;
   } cbt_stat_type;

   typedef struct packed {
      logic              stop;
      logic              bt;
      logic              set_flag;
      logic              flag_val;
      logic              set_quote;
      logic [TAKE_W-1:0] ntake;
      logic              emit;
      logic [KIND_W-1:0] kind;
      cbt_mode_type      mode_next;
   } cbt_dec_type;

   function automatic logic is_space(input logic [BYTE_W-1:0] c);
      return (c == " ") || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_start(input logic [BYTE_W-1:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c[7];
   endfunction

   function automatic logic is_body(input logic [BYTE_W-1:0] c);
      return is_start(c) || is_digit(c) || c == "-";
   endfunction

   // {valid, kind}
   function automatic logic [KIND_W:0] punct_kind(input logic [BYTE_W-1:0] c);
      logic [KIND_W:0] r;
      unique case (c)
         ":":     r = {1'b1, 5'd0};
         ";":     r = {1'b1, 5'd1};
         ",":     r = {1'b1, 5'd2};
         "{":     r = {1'b1, 5'd3};
         "}":     r = {1'b1, 5'd4};
         "(":     r = {1'b1, 5'd5};
         ")":     r = {1'b1, 5'd6};
         "[":     r = {1'b1, 5'd7};
         "]":     r = {1'b1, 5'd8};
         "+":     r = {1'b1, 5'd10};
         "*":     r = {1'b1, 5'd12};
         ">":     r = {1'b1, 5'd14};
         "~":     r = {1'b1, 5'd15};
         "|":     r = {1'b1, 5'd16};
         "^":     r = {1'b1, 5'd17};
         "$":     r = {1'b1, 5'd18};
         "=":     r = {1'b1, 5'd19};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> design/cbt_if.sv
`timescale 1ns / 1ps

interface cbt_req_if import cbt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              end_of_text;

   modport source(output valid, text_byte, end_of_text, input ready);
   modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface cbt_rsp_if import cbt_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  token_kind;
   logic [FIELD_W-1:0] start_offset;
   logic [FIELD_W-1:0] lexeme_length;
   logic [FIELD_W-1:0] start_line;
   logic [FIELD_W-1:0] start_column;
   logic               hash_is_id;
   logic               last_of_run;

   modport source(output valid, token_kind, start_offset, lexeme_length, start_line,
                  start_column, hash_is_id, last_of_run, input ready);
   modport sink(input valid, token_kind, start_offset, lexeme_length, start_line,
                start_column, hash_is_id, last_of_run, output ready);
endinterface

>>> design/cbt_decode.sv
`timescale 1ns / 1ps

module cbt_decode import cbt_pkg::*; (
   input  cbt_mode_type      mode,
   input  logic [CNT_W-1:0]  count,
   input  logic [BYTE_W-1:0] look [LOOK],
   input  logic              ending,
   input  logic [BYTE_W-1:0] quote,
   output cbt_dec_type       dec
);

   logic [LOOK-1:0]   av;
   logic [BYTE_W-1:0] mt_word [MATCH_MAX];
   logic [TAKE_W-1:0] mt_len;
   logic              mt_stall;
   logic              mt_err;
   logic [BYTE_W-1:0] c0;
   logic [BYTE_W-1:0] c1;
   logic              dig0;
   logic              dig1;
   logic              dig2;
   logic              body0;
   logic [KIND_W:0]   pk;
   logic              tail;

   always_comb begin
      for (int i = 0; i < LOOK; i++) begin
         av[i] = int'(count) > i;
      end
   end

   assign c0    = look[0];
   assign c1    = look[1];
   assign dig0  = av[0] && is_digit(c0);
   assign dig1  = av[1] && is_digit(c1);
   assign dig2  = av[2] && is_digit(look[2]);
   assign body0 = av[0] && is_body(c0);
   assign pk    = punct_kind(c0);

   always_comb begin
      for (int i = 0; i < MATCH_MAX; i++) begin
         mt_word[i] = (c0 == "!") ? IMPORTANT_WORD[i] : CDO_WORD[i];
      end
   end

   assign mt_len  = (c0 == "!") ? IMPORTANT_LEN : CDO_LEN;

   // stop at the first byte that is missing or differs
   always_comb begin
      mt_stall = 1'b0;
      mt_err   = 1'b0;
      for (int i = 1; i <= MATCH_MAX; i++) begin
         if (i <= int'(mt_len) && !mt_stall && !mt_err) begin
            if (!av[i]) begin
               if (ending) begin
                  mt_err = 1'b1;
               end else begin
                  mt_stall = 1'b1;
               end
            end else if (look[i] != mt_word[i-1]) begin
               mt_err = 1'b1;
            end
         end
      end
   end

   always_comb begin
      dec = '0;
      dec.mode_next = mode;
      tail = 1'b0;
      if (mode == M_IDLE) begin
         if (!av[0]) begin
            dec.stop = 1'b1;
         end else if (is_space(c0)) begin
            dec.ntake = 4'd1;
         end else begin
            dec.bt = 1'b1;
            if (pk[KIND_W]) begin
               dec.ntake = 4'd1;
               dec.emit  = 1'b1;
               dec.kind  = pk[KIND_W-1:0];
            end else begin
               unique case (c0)
                  ".": begin
                     if (!av[1] && !ending) begin
                        dec.stop = 1'b1;
                     end else begin
                        dec.ntake = 4'd1;
                        if (dig1) begin
                           dec.mode_next = M_NUMFRAC;
                        end else begin
                           dec.emit = 1'b1;
                           dec.kind = K_DOT;
                        end
                     end
                  end
                  "-": begin
                     if (!av[1] && !ending) begin
                        dec.stop = 1'b1;
                     end else if (dig1) begin
                        dec.ntake = 4'd1;
                        dec.mode_next = M_NUMINT;
                     end else if (av[1] && c1 == ".") begin
                        if (!av[2] && !ending) begin
                           dec.stop = 1'b1;
                        end else begin
                           dec.ntake = 4'd1;
                           if (dig2) begin
                              dec.mode_next = M_NUMINT;
                           end else begin
                              dec.emit = 1'b1;
                              dec.kind = K_MINUS;
                           end
                        end
                     end else if (av[1] && c1 == "-") begin
                        dec.ntake = 4'd2;
                        dec.mode_next = M_IDENT;
                     end else begin
                        dec.ntake = 4'd1;
                        dec.emit  = 1'b1;
                        dec.kind  = K_MINUS;
                     end
                  end
                  "/": begin
                     if (!av[1] && !ending) begin
                        dec.stop = 1'b1;
                     end else if (av[1] && c1 == "*") begin
                        dec.ntake = 4'd2;
                        dec.mode_next = M_COMMENT;
                     end else begin
                        dec.ntake = 4'd1;
                        dec.emit  = 1'b1;
                        dec.kind  = K_SLASH;
                     end
                  end
                  "#": begin
                     if (!av[1] && !ending) begin
                        dec.stop = 1'b1;
                     end else begin
                        dec.set_flag  = 1'b1;
                        dec.flag_val  = av[1] && is_start(c1);
                        dec.ntake     = 4'd1;
                        dec.mode_next = M_HASH;
                     end
                  end
                  "@": begin
                     dec.ntake = 4'd1;
                     dec.mode_next = M_AT;
                  end
                  "\"", "'": begin
                     dec.set_quote = 1'b1;
                     dec.ntake = 4'd1;
                     dec.mode_next = M_STRING;
                  end
                  "!", "<": begin
                     if (mt_stall) begin
                        dec.stop = 1'b1;
                     end else if (mt_err) begin
                        dec.ntake = 4'd1;
                        dec.emit  = 1'b1;
                        dec.kind  = K_ERROR;
                     end else begin
                        dec.ntake = mt_len + 4'd1;
                        dec.emit  = 1'b1;
                        dec.kind  = (c0 == "!") ? K_IMPORTANT : K_CDO;
                     end
                  end
                  default: begin
                     dec.ntake = 4'd1;
                     if (is_start(c0)) begin
                        dec.mode_next = M_IDENT;
                     end else if (is_digit(c0)) begin
                        dec.mode_next = M_NUMINT;
                     end else begin
                        dec.emit = 1'b1;
                        dec.kind = K_ERROR;
                     end
                  end
               endcase
            end
         end
      end else if (!av[0] && !ending) begin
         dec.stop = 1'b1;
      end else begin
         unique case (mode)
            M_IDENT, M_HASH, M_AT, M_UNIT: begin
               if (body0) begin
                  dec.ntake = 4'd1;
               end else begin
                  dec.emit = 1'b1;
                  dec.mode_next = M_IDLE;
                  unique case (mode)
                     M_IDENT: dec.kind = (av[0] && c0 == "(") ? K_FUNCTION : K_IDENT;
                     M_HASH:  dec.kind = K_HASH;
                     M_AT:    dec.kind = K_ATKW;
                     default: dec.kind = K_DIMENSION;
                  endcase
               end
            end
            M_NUMINT: begin
               if (dig0) begin
                  dec.ntake = 4'd1;
               end else if (av[0] && c0 == ".") begin
                  if (!av[1] && !ending) begin
                     dec.stop = 1'b1;
                  end else if (dig1) begin
                     dec.ntake = 4'd1;
                     dec.mode_next = M_NUMFRAC;
                  end else begin
                     tail = 1'b1;
                  end
               end else begin
                  tail = 1'b1;
               end
            end
            M_NUMFRAC: begin
               if (dig0) begin
                  dec.ntake = 4'd1;
               end else begin
                  tail = 1'b1;
               end
            end
            M_STRING: begin
               if (!av[0]) begin
                  dec.emit = 1'b1;
                  dec.kind = K_STRING;
                  dec.mode_next = M_IDLE;
               end else if (c0 == quote) begin
                  dec.ntake = 4'd1;
                  dec.emit = 1'b1;
                  dec.kind = K_STRING;
                  dec.mode_next = M_IDLE;
               end else if (c0 == "\\") begin
                  dec.ntake = 4'd1;
                  dec.mode_next = M_STRESC;
               end else begin
                  dec.ntake = 4'd1;
               end
            end
            M_STRESC: begin
               if (!av[0]) begin
                  dec.emit = 1'b1;
                  dec.kind = K_STRING;
                  dec.mode_next = M_IDLE;
               end else begin
                  dec.ntake = 4'd1;
                  dec.mode_next = M_STRING;
               end
            end
            M_COMMENT: begin
               if (!av[0]) begin
                  dec.mode_next = M_IDLE;
               end else if (c0 == "*" && !av[1] && !ending) begin
                  dec.stop = 1'b1;
               end else if (c0 == "*" && av[1] && c1 == "/") begin
                  dec.ntake = 4'd2;
                  dec.mode_next = M_IDLE;
               end else begin
                  dec.ntake = 4'd1;
               end
            end
            default: dec.mode_next = M_IDLE;
         endcase
      end

      // number suffix: percent, unit or plain number
      if (tail) begin
         if (av[0] && c0 == "%") begin
            dec.ntake = 4'd1;
            dec.emit = 1'b1;
            dec.kind = K_PERCENT;
            dec.mode_next = M_IDLE;
         end else if (av[0] && (is_start(c0) || c0 == "-")) begin
            dec.ntake = 4'd1;
            dec.mode_next = M_UNIT;
         end else begin
            dec.emit = 1'b1;
            dec.kind = K_NUMBER;
            dec.mode_next = M_IDLE;
         end
      end
   end

endmodule

>>> design/cbt_datapath.sv
`timescale 1ns / 1ps

module cbt_datapath import cbt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cbt_cmd_type       cmd,
   output cbt_stat_type      stat,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              in_end,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output cbt_token_type     rsp_token,
   output logic              rsp_last
);

   logic [BYTE_W-1:0]      queue_ff [REPLAY_DEPTH];
   logic [BYTE_W-1:0]      look [LOOK];
   logic [CNT_W-1:0]       count_ff, count_in;
   cbt_mode_type           mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] tbegin_ff, tbegin_in;
   logic [FIELD_W-1:0]     line_ff, line_in;
   logic [FIELD_W-1:0]     col_ff, col_in;
   logic [FIELD_W-1:0]     bline_ff, bline_in;
   logic [FIELD_W-1:0]     bcol_ff, bcol_in;
   logic [FIELD_W-1:0]     run_ff, run_in;
   logic [BYTE_W-1:0]      quote_ff, quote_in;
   logic [3:0]             flags_ff, flags_in;
   logic                   ending_ff, ending_in;
   logic [TAKE_W-1:0]      take_cnt_ff, take_cnt_in;
   logic                   emit_pend_ff, emit_pend_in;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   cbt_token_type          held_ff, held_in;
   logic                   held_valid_ff, held_valid_in;
   cbt_token_type          out_ff, out_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_valid_ff, out_valid_in;
   cbt_dec_type            dec;

   always_comb begin
      for (int i = 0; i < LOOK; i++) begin
         look[i] = queue_ff[i];
      end
   end

   cbt_decode u_decode (
      .mode   (mode_ff),
      .count  (count_ff),
      .look   (look),
      .ending (ending_ff),
      .quote  (quote_ff),
      .dec    (dec)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         if (count_ff < CNT_W'(REPLAY_DEPTH)) begin
            queue_ff[count_ff[IDX_W-1:0]] <= in_byte;
         end
      end else if (cmd.take) begin
         for (int i = 0; i < REPLAY_DEPTH - 1; i++) begin
            queue_ff[i] <= queue_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in      = count_ff;
      mode_in       = mode_ff;
      pos_in        = pos_ff;
      tbegin_in     = tbegin_ff;
      line_in       = line_ff;
      col_in        = col_ff;
      bline_in      = bline_ff;
      bcol_in       = bcol_ff;
      run_in        = run_ff;
      quote_in      = quote_ff;
      flags_in      = flags_ff;
      ending_in     = ending_ff;
      take_cnt_in   = take_cnt_ff;
      emit_pend_in  = emit_pend_ff;
      kind_in       = kind_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.load_byte) begin
         ending_in = in_end;
         if (count_ff < CNT_W'(REPLAY_DEPTH)) begin
            count_in = count_ff + 1'b1;
         end
      end

      if (cmd.apply) begin
         mode_in      = dec.mode_next;
         take_cnt_in  = dec.ntake;
         emit_pend_in = dec.emit;
         kind_in      = dec.kind;
         if (dec.bt) begin
            tbegin_in = pos_ff;
            bline_in  = line_ff;
            bcol_in   = col_ff;
            run_in    = '0;
            flags_in  = '0;
         end
         if (dec.set_flag) begin
            flags_in = {3'b000, dec.flag_val};
         end
         if (dec.set_quote) begin
            quote_in = queue_ff[0];
         end
      end

      if (cmd.take) begin
         take_cnt_in = take_cnt_ff - 1'b1;
         count_in    = count_ff - 1'b1;
         pos_in      = pos_ff + 1'b1;
         if (run_ff != '1) begin
            run_in = run_ff + 1'b1;
         end
         if (queue_ff[0] == CH_LF) begin
            if (line_ff != '1) begin
               line_in = line_ff + 1'b1;
            end
            col_in = FIELD_W'(1);
         end else if (col_ff != '1) begin
            col_in = col_ff + 1'b1;
         end
      end

      // a new token pushes the one held before it out, not yet last
      if ((cmd.emit || cmd.end_tok) && held_valid_ff) begin
         out_in       = held_ff;
         out_last_in  = 1'b0;
         out_valid_in = 1'b1;
      end

      if (cmd.emit) begin
         emit_pend_in    = 1'b0;
         held_in.kind    = kind_ff;
         held_in.offset  = FIELD_W'(tbegin_ff);
         held_in.length  = run_ff;
         held_in.line    = bline_ff;
         held_in.column  = bcol_ff;
         held_in.hash_id = (kind_ff == K_HASH) && flags_ff[0];
         held_valid_in   = 1'b1;
      end

      if (cmd.end_tok) begin
         held_in.kind    = K_END;
         held_in.offset  = FIELD_W'(pos_ff);
         held_in.length  = '0;
         held_in.line    = line_ff;
         held_in.column  = col_ff;
         held_in.hash_id = 1'b0;
         held_valid_in   = 1'b1;
         // back to the state after reset for the next text
         mode_in      = M_IDLE;
         count_in     = '0;
         pos_in       = '0;
         tbegin_in    = '0;
         line_in      = FIELD_W'(1);
         col_in       = FIELD_W'(1);
         bline_in     = FIELD_W'(1);
         bcol_in      = FIELD_W'(1);
         run_in       = '0;
         quote_in     = '0;
         flags_in     = '0;
         ending_in    = 1'b0;
         take_cnt_in  = '0;
         emit_pend_in = 1'b0;
      end

      if (cmd.flush) begin
         out_in        = held_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         mode_ff       <= M_IDLE;
         pos_ff        <= '0;
         tbegin_ff     <= '0;
         line_ff       <= FIELD_W'(1);
         col_ff        <= FIELD_W'(1);
         bline_ff      <= FIELD_W'(1);
         bcol_ff       <= FIELD_W'(1);
         run_ff        <= '0;
         quote_ff      <= '0;
         flags_ff      <= '0;
         ending_ff     <= 1'b0;
         take_cnt_ff   <= '0;
         emit_pend_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         mode_ff       <= mode_in;
         pos_ff        <= pos_in;
         tbegin_ff     <= tbegin_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         bline_ff      <= bline_in;
         bcol_ff       <= bcol_in;
         run_ff        <= run_in;
         quote_ff      <= quote_in;
         flags_ff      <= flags_in;
         ending_ff     <= ending_in;
         take_cnt_ff   <= take_cnt_in;
         emit_pend_ff  <= emit_pend_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      held_ff     <= held_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign stat.stop       = dec.stop;
   assign stat.ending     = ending_ff;
   assign stat.takes_left = take_cnt_ff != '0;
   assign stat.emit_pend  = emit_pend_ff;
   assign stat.held_valid = held_valid_ff;
   assign stat.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid = out_valid_ff;
   assign rsp_token = out_ff;
   assign rsp_last  = out_last_ff;

endmodule

>>> design/cbt_ctrl.sv
`timescale 1ns / 1ps

module cbt_ctrl import cbt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  cbt_stat_type stat,
   output cbt_cmd_type  cmd
);

   cbt_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_WAIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_WAIT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_byte = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (stat.stop) begin
               state_in = stat.ending ? ST_END : ST_FLUSH;
            end else begin
               cmd.apply = 1'b1;
               state_in = ST_TAKE;
            end
         end
         ST_TAKE: begin
            if (stat.takes_left) begin
               cmd.take = 1'b1;
            end else if (stat.emit_pend) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_RUN;
            end
         end
         ST_EMIT: begin
            // hold until the output register can take the previous token
            if (!stat.held_valid || stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_END: begin
            if (!stat.held_valid || stat.out_free) begin
               cmd.end_tok = 1'b1;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!stat.held_valid) begin
               state_in = ST_WAIT;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in = ST_WAIT;
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

endmodule

>>> design/css_byte_tokenizer.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload
// req_bus   in   text_byte, end_of_text
// rsp_bus   out  token_kind, start_offset, lexeme_length, start_line,
//                start_column, hash_is_id, last_of_run
//
// One request at a time: the byte is accepted, then each lexer step decodes,
// consumes its bytes one by one, leaves the consume loop and emits its token,
// and the run closes with a flush (after the end token at the end of the text);
// a failed lookahead adds the steps that re-lex the queue.
// Reset is synchronous; the queue contents are not cleared.
// A stalled result holds the loop when a further token or the closing flush
// needs the output register.

module css_byte_tokenizer import cbt_pkg::*; (
   input logic       clock,
   input logic       reset,
   cbt_req_if.sink   req_bus,
   cbt_rsp_if.source rsp_bus
);

   cbt_cmd_type   cmd;
   cbt_stat_type  stat;
   cbt_token_type token;
   logic          last;

   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cbt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .in_byte   (req_bus.text_byte),
      .in_end    (req_bus.end_of_text),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_token (token),
      .rsp_last  (last)
   );

   assign rsp_bus.token_kind    = token.kind;
   assign rsp_bus.start_offset  = token.offset;
   assign rsp_bus.lexeme_length = token.length;
   assign rsp_bus.start_line    = token.line;
   assign rsp_bus.start_column  = token.column;
   assign rsp_bus.hash_is_id    = token.hash_id;
   assign rsp_bus.last_of_run   = last;

endmodule

>>> bench/cbt_test_if.sv
`timescale 1ns / 1ps

package cbt_test_pkg;
   import cbt_pkg::*;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [FIELD_W-1:0] offset;
      logic [FIELD_W-1:0] length;
      logic [FIELD_W-1:0] line;
      logic [FIELD_W-1:0] column;
      logic               hash_id;
      logic               last;
   } token_rec_type;

   typedef struct {
      logic [7:0] text;
      logic       eot;
   } text_rec_type;
endpackage

>>> bench/css_byte_tokenizer_test.sv
`timescale 1ns / 1ps

module css_byte_tokenizer_test;
   import cbt_pkg::*;
   import cbt_test_pkg::*;

   localparam int WATCHDOG   = 20000;
   localparam int MAX_TOKENS = 12;
   localparam int NO_KIND    = -1;
   localparam int REC_W      = KIND_W + 4 * FIELD_W + 2;

   localparam logic [4:0] KD_COLON = 5'd0;
   localparam logic [4:0] KD_PLUS  = 5'd10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cbt_req_if req_bus ();
   cbt_rsp_if rsp_bus ();

   css_byte_tokenizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   // Lexer state mirrored from the block's behavior.
   cbt_mode_type  lx_mode;
   logic [7:0]    lx_queue [$];
   logic [15:0]   lx_begin, lx_pos, lx_line, lx_col, lx_bline, lx_bcol, lx_len;
   logic [7:0]    lx_quote;
   logic          lx_flag, lx_ending;
   token_rec_type step_tokens [$];
   token_rec_type expected_tokens [$];
   int            want_kind [$];
   int            row_kind = NO_KIND;

   int  errors = 0;
   int  send_idle = 27, recv_idle = 47;
   int  quiet = 0;

   function automatic void lexer_clear();
      lx_mode = M_IDLE; lx_queue.delete();
      lx_begin = 0; lx_pos = 0; lx_line = 1; lx_col = 1;
      lx_bline = 1; lx_bcol = 1; lx_quote = 0; lx_flag = 0; lx_len = 0;
   endfunction

   function automatic int peek(int i);
      if (i >= lx_queue.size()) return -1;
      return lx_queue[i];
   endfunction

   function automatic logic c_space(int c);
      return c == 32 || (c >= 9 && c <= 13);
   endfunction
   function automatic logic c_digit(int c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic logic c_start(int c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c >= 128;
   endfunction
   function automatic logic c_body(int c);
      return c_start(c) || c_digit(c) || c == "-";
   endfunction

   function automatic int punct_code(int c);
      case (c)
         ":": return 0;  ";": return 1;  ",": return 2;  "{": return 3;
         "}": return 4;  "(": return 5;  ")": return 6;  "[": return 7;
         "]": return 8;  "+": return 10; "*": return 12; ">": return 14;
         "~": return 15; "|": return 16; "^": return 17; "$": return 18;
         "=": return 19;
         default: return -1;
      endcase
   endfunction

   function automatic void consume();
      logic [7:0] b;
      if (lx_queue.size() == 0) return;
      b = lx_queue.pop_front();
      lx_pos++;
      if (lx_len != 16'hFFFF) lx_len++;
      if (b == CH_LF) begin
         if (lx_line != 16'hFFFF) lx_line++;
         lx_col = 1;
      end else if (lx_col != 16'hFFFF) lx_col++;
   endfunction

   function automatic void mark();
      lx_begin = lx_pos; lx_bline = lx_line; lx_bcol = lx_col; lx_len = 0; lx_flag = 0;
   endfunction

   function automatic void put(logic [4:0] k);
      token_rec_type t;
      if (step_tokens.size() >= MAX_TOKENS) return;
      t.kind = k; t.offset = lx_begin; t.length = lx_len; t.line = lx_bline;
      t.column = lx_bcol; t.hash_id = (k == K_HASH) ? lx_flag : 1'b0; t.last = 0;
      step_tokens.insert(step_tokens.size(), t);
   endfunction

   function automatic void close_tok(logic [4:0] k);
      put(k); lx_mode = M_IDLE;
   endfunction

   function automatic logic need(int i);
      return i < lx_queue.size() || lx_ending;
   endfunction

   function automatic void number_end(int b);
      if (b == "%") begin consume(); close_tok(K_PERCENT); end
      else if (c_start(b) || b == "-") begin consume(); lx_mode = M_UNIT; end
      else close_tok(K_NUMBER);
   endfunction

   function automatic logic match_word(string w, logic [4:0] k);
      for (int i = 1; i <= w.len(); i++) begin
         if (!need(i)) return 0;
         if (peek(i) != w[i-1]) begin consume(); put(K_ERROR); return 1; end
      end
      for (int i = 0; i <= w.len(); i++) consume();
      put(k);
      return 1;
   endfunction

   function automatic logic lex_idle();
      int c, k, b;
      if (!need(0)) return 0;
      c = peek(0);
      if (c < 0) return 0;
      if (c_space(c)) begin consume(); return 1; end
      mark();
      k = punct_code(c);
      if (k >= 0) begin consume(); put(k[4:0]); return 1; end
      case (c)
         ".": begin
            if (!need(1)) return 0;
            consume();
            if (c_digit(peek(0))) lx_mode = M_NUMFRAC; else put(K_DOT);
            return 1;
         end
         "-": begin
            if (!need(1)) return 0;
            b = peek(1);
            if (c_digit(b)) begin consume(); lx_mode = M_NUMINT; end
            else if (b == ".") begin
               if (!need(2)) return 0;
               consume();
               if (c_digit(peek(1))) lx_mode = M_NUMINT; else put(K_MINUS);
            end else if (b == "-") begin consume(); consume(); lx_mode = M_IDENT; end
            else begin consume(); put(K_MINUS); end
            return 1;
         end
         "/": begin
            if (!need(1)) return 0;
            if (peek(1) == "*") begin consume(); consume(); lx_mode = M_COMMENT; end
            else begin consume(); put(K_SLASH); end
            return 1;
         end
         "#": begin
            if (!need(1)) return 0;
            lx_flag = c_start(peek(1));
            consume(); lx_mode = M_HASH;
            return 1;
         end
         "@": begin consume(); lx_mode = M_AT; return 1; end
         "\"", "'": begin
            lx_quote = 8'(c); consume(); lx_mode = M_STRING; return 1;
         end
         "!": return match_word("important", K_IMPORTANT);
         "<": return match_word("!--", K_CDO);
         default: ;
      endcase
      consume();
      if (c_start(c)) lx_mode = M_IDENT;
      else if (c_digit(c)) lx_mode = M_NUMINT;
      else put(K_ERROR);
      return 1;
   endfunction

   function automatic logic lex_advance();
      int b;
      if (lx_mode == M_IDLE) return lex_idle();
      if (!need(0)) return 0;
      b = peek(0);
      case (lx_mode)
         M_IDENT: if (c_body(b)) consume();
                  else close_tok(b == "(" ? K_FUNCTION : K_IDENT);
         M_HASH:  if (c_body(b)) consume(); else close_tok(K_HASH);
         M_AT:    if (c_body(b)) consume(); else close_tok(K_ATKW);
         M_UNIT:  if (c_body(b)) consume(); else close_tok(K_DIMENSION);
         M_NUMINT: begin
            if (c_digit(b)) consume();
            else if (b == "." && !need(1)) return 0;
            else if (b == "." && c_digit(peek(1))) begin consume(); lx_mode = M_NUMFRAC; end
            else number_end(b);
         end
         M_NUMFRAC: if (c_digit(b)) consume(); else number_end(b);
         M_STRING: begin
            if (b < 0) close_tok(K_STRING);
            else if (b == lx_quote) begin consume(); close_tok(K_STRING); end
            else if (b == "\\") begin consume(); lx_mode = M_STRESC; end
            else consume();
         end
         M_STRESC: if (b < 0) close_tok(K_STRING); else begin consume(); lx_mode = M_STRING; end
         M_COMMENT: begin
            if (b < 0) lx_mode = M_IDLE;
            else if (b == "*" && !need(1)) return 0;
            else if (b == "*" && peek(1) == "/") begin consume(); consume(); lx_mode = M_IDLE; end
            else consume();
         end
         default: lx_mode = M_IDLE;
      endcase
      return 1;
   endfunction

   // Run the lexer over one request and queue the tokens it yields.
   // The first token after a directed row starts carries that row's typed kind.
   function automatic void predict_tokens(logic [7:0] text, logic eot);
      step_tokens.delete();
      lx_ending = eot;
      if (lx_queue.size() < REPLAY_DEPTH) lx_queue.insert(lx_queue.size(), text);
      forever begin
         if (lx_mode == M_IDLE && lx_queue.size() == 0) break;
         if (!lex_advance()) break;
      end
      if (eot) begin
         mark(); put(K_END); lexer_clear();
      end
      if (step_tokens.size() > 0) step_tokens[$].last = 1;
      foreach (step_tokens[i]) begin
         expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
         want_kind.insert(want_kind.size(), row_kind);
         row_kind = NO_KIND;
      end
   endfunction

   // Directed table; NO_KIND means predictor only, else the row's first token kind.
   text_rec_type dir_text [$];
   int           dir_kind [$];

   task automatic add_text(string s, logic eot_last, int first_kind);
      text_rec_type r;
      for (int i = 0; i < s.len(); i++) begin
         r.text = s[i]; r.eot = eot_last && (i == s.len() - 1);
         dir_text.insert(dir_text.size(), r);
         dir_kind.insert(dir_kind.size(), i == 0 ? first_kind : NO_KIND);
      end
   endtask

   task automatic send(logic [7:0] text, logic eot);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1; req_bus.text_byte <= text; req_bus.end_of_text <= eot;
      predict_tokens(text, eot);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   string css_pieces [16] = '{"a{b:1}", "#x1 ", "@media ", "12.5% ", "-7px", ".5em",
      "\"s\\\"t\"", "'u'", "/*c*/", "!important", "<!--", "foo(", "--v", "\n", "[|=]",
      "!imp"};

   always @(posedge clock) begin
      token_rec_type e;
      int            w;
      logic [REC_W-1:0] exp_v, got_v;
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: expected no token, got kind %0d", $time, rsp_bus.token_kind);
         end else begin
            e = expected_tokens.pop_front();
            w = want_kind.pop_front();
            exp_v = {e.kind, e.offset, e.length, e.line, e.column, e.hash_id, e.last};
            got_v = {rsp_bus.token_kind, rsp_bus.start_offset, rsp_bus.lexeme_length,
                     rsp_bus.start_line, rsp_bus.start_column, rsp_bus.hash_is_id,
                     rsp_bus.last_of_run};
            if (exp_v !== got_v) begin
               errors++;
               $display("%0t: expected %h, got %h", $time, exp_v, got_v);
            end
            if (w != NO_KIND && int'(rsp_bus.token_kind) != w) begin
               errors++;
               $display("%0t: expected kind %0d, got kind %0d", $time, w,
                        rsp_bus.token_kind);
            end
         end
      end
   end

   // Count cycles with no request or token moving.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int n, phase;
      string s;
      req_bus.valid = 1'b0; req_bus.text_byte = 8'h00; req_bus.end_of_text = 1'b0;
      lexer_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      add_text(":", 1'b0, KD_COLON);
      add_text("+", 1'b0, KD_PLUS);
      add_text("!impx ", 1'b0, K_ERROR);
      add_text("<!x ", 1'b0, K_ERROR);
      add_text("\001", 1'b0, K_ERROR);
      add_text("\377\200 #9", 1'b0, NO_KIND);
      add_text("'ab", 1'b1, NO_KIND);
      add_text("/*z", 1'b1, K_END);
      foreach (dir_text[i]) begin
         if (dir_kind[i] != NO_KIND) row_kind = dir_kind[i];
         send(dir_text[i].text, dir_text[i].eot);
      end

      for (phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 27 : (phase == 1) ? 47 : 0;
         recv_idle = (phase == 0) ? 47 : (phase == 1) ? 27 : 0;
         n = 0;
         while (n < 140) begin
            if ($urandom_range(99) < 80) begin
               s = css_pieces[$urandom_range(15)];
               for (int i = 0; i < s.len(); i++) begin
                  send(s[i], 1'b0); n++;
               end
            end else begin
               send(8'($urandom_range(255)), $urandom_range(99) < 4); n++;
            end
         end
         send(8'h0A, 1'b1);
      end
      req_bus.valid <= 1'b0;
      n = 0;
      while (expected_tokens.size() > 0 && n < WATCHDOG) begin
         @(posedge clock); n++;
      end
      repeat (50) @(posedge clock);
      if (errors == 0 && expected_tokens.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
